/* rtl/asobs_pkg.sv */
// ----------------------------------------------------------------------------
// asobs_pkg: shared types and constants of the angle/speed observer
// Widths, register indexes, controller states and the command word that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package asobs_pkg;

	// default angle resolution, 2^ANGLE_BITS LSB per turn
	localparam int ANGLE_BITS_DEF = 16;

	// field and register widths
	localparam int GAIN_W       = 32;
	localparam int LIMIT_W      = 31;
	localparam int CFG_IDX_W    = 3;
	localparam int ANGLE_IN_W   = 16;
	localparam int ANGLE_OUT_W  = 16;
	localparam int SPEED_W      = 32;
	localparam int TRACK_W      = 32;

	// internal arithmetic widths
	localparam int INTEG_W  = 48;  // integrator, Q32.16
	localparam int HAT_W    = 48;  // clamped speed, |hat| < 2^47
	localparam int RES_W    = 63;  // saturated product, +-2^61
	localparam int UNSAT_W  = 58;  // P term (< 2^55) plus integrator
	localparam int DIFF_W   = 59;  // clamped minus unclamped speed
	localparam int OPND_W   = 64;  // multiplier operand, two 32 bit halves
	localparam int PROD_W   = 66;  // 33 x 33 signed product
	localparam int FULL_W   = 98;  // recombined product

	localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RST = 32'd214748;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN     = 3'd0,
		CFG_INTEG_GAIN    = 3'd1,
		CFG_WINDUP_GAIN   = 3'd2,
		CFG_SAMPLE_PERIOD = 3'd3,
		CFG_SPEED_LIMIT   = 3'd4
	} cfg_idx_t;

	// phase of one multiply through the shared multiplier
	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LO,
		MP_HI,
		MP_FIN
	} mul_phase_t;

	// gain and operand pairs fed to the multiplier
	typedef enum logic [2:0] {
		MS_KP_ERR,
		MS_KI_ERR,
		MS_KAW_DIFF,
		MS_T_DELTA,
		MS_T_HAT
	} mul_sel_t;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_LO,
		ST_P_HI,
		ST_P_FIN,
		ST_HAT,
		ST_S_LO,
		ST_S_HI,
		ST_S_FIN,
		ST_I_LO,
		ST_I_HI,
		ST_I_FIN,
		ST_W_LO,
		ST_W_HI,
		ST_W_FIN,
		ST_DELTA,
		ST_D_LO,
		ST_D_HI,
		ST_D_FIN,
		ST_INTEG,
		ST_OUT
	} state_t;

	// controller to datapath command word
	typedef struct packed {
		logic       load;      // capture sample, form wrapped error
		mul_phase_t mphase;
		mul_sel_t   msel;
		logic       hat_en;    // unclamped speed, clamp, flag
		logic       diff_en;   // clamped minus unclamped
		logic       angle_en;  // tracked angle update
		logic       keep_i;    // hold integral product
		logic       delta_en;  // integral plus anti-windup term
		logic       integ_en;  // integrator update
		logic       out_load;  // load result word
	} dp_cmd_t;

endpackage

/* rtl/asobs_sample_if.sv */
// ----------------------------------------------------------------------------
// asobs_sample_if: input channel of the observer
// One word carries one measured encoder angle.
// ----------------------------------------------------------------------------
interface asobs_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic [asobs_pkg::ANGLE_IN_W-1:0]     measured_angle;

	modport source (output valid, output measured_angle, input ready);
	modport sink (input valid, input measured_angle, output ready);
endinterface

/* rtl/asobs_result_if.sv */
// ----------------------------------------------------------------------------
// asobs_result_if: output channel of the observer
// One word carries speed estimate, angle estimate and clamp flag.
// ----------------------------------------------------------------------------
interface asobs_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [asobs_pkg::SPEED_W-1:0]    speed_estimate;
	logic [asobs_pkg::ANGLE_OUT_W-1:0]       angle_estimate;
	logic                                    speed_clamped;

	modport source (output valid, output speed_estimate, output angle_estimate,
		output speed_clamped, input ready);
	modport sink (input valid, input speed_estimate, input angle_estimate,
		input speed_clamped, output ready);
endinterface

/* rtl/pll_angle_speed_observer_top.sv */
// ----------------------------------------------------------------------------
// pll_angle_speed_observer_top: angle and speed tracking observer
// Each sample word is first taken and its wrapped error formed, then five
// multiplies (kp*err, T*speed, ki*err, kaw*(clamped - unclamped), T*delta)
// run in lo, hi and fin phases on one shared 33x33 multiplier,
// plus the clamp, delta, integrator and result steps. The result sits in an
// output register; a new sample is taken as soon as the sequencer is back in
// idle, and the sequencer waits before loading a result only while the
// previous one has not been taken. Angles are fractions of a turn,
// 2^ANGLE_BITS LSB per turn; speeds are in angle LSB per second.
// ----------------------------------------------------------------------------
module pll_angle_speed_observer_top #(
	parameter int ANGLE_BITS = asobs_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [asobs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asobs_pkg::GAIN_W-1:0]     cfg_wdata,
	asobs_sample_if.sink                     sample,
	asobs_result_if.source                   result
);

	asobs_pkg::dp_cmd_t cmd;

	// sequencer
	asobs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// datapath
	asobs_dp #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.measured_angle (sample.measured_angle),
		.cmd            (cmd),
		.speed_estimate (result.speed_estimate),
		.angle_estimate (result.angle_estimate),
		.speed_clamped  (result.speed_clamped)
	);

endmodule

/* rtl/asobs_ctrl.sv */
// ----------------------------------------------------------------------------
// asobs_ctrl: observer sequencer
// Walks one sample through five multiplies on the shared multiplier and the
// clamp, integrator and angle updates, then hands the result word over.
// ----------------------------------------------------------------------------
module asobs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output asobs_pkg::dp_cmd_t  cmd
);

	asobs_pkg::state_t state_q;
	asobs_pkg::state_t state_next;
	logic              out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asobs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next   = state_q;
		cmd          = '0;
		cmd.mphase   = asobs_pkg::MP_IDLE;
		cmd.msel     = asobs_pkg::MS_KP_ERR;
		in_ready     = 1'b0;
		case (state_q)
			asobs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = asobs_pkg::ST_P_LO;
				end
			end
			// proportional term
			asobs_pkg::ST_P_LO: begin
				cmd.mphase = asobs_pkg::MP_LO;
				state_next = asobs_pkg::ST_P_HI;
			end
			asobs_pkg::ST_P_HI: begin
				cmd.mphase = asobs_pkg::MP_HI;
				state_next = asobs_pkg::ST_P_FIN;
			end
			asobs_pkg::ST_P_FIN: begin
				cmd.mphase = asobs_pkg::MP_FIN;
				state_next = asobs_pkg::ST_HAT;
			end
			asobs_pkg::ST_HAT: begin
				cmd.hat_en = 1'b1;
				state_next = asobs_pkg::ST_S_LO;
			end
			// angle step, period times clamped speed
			asobs_pkg::ST_S_LO: begin
				cmd.mphase  = asobs_pkg::MP_LO;
				cmd.msel    = asobs_pkg::MS_T_HAT;
				cmd.diff_en = 1'b1;
				state_next  = asobs_pkg::ST_S_HI;
			end
			asobs_pkg::ST_S_HI: begin
				cmd.mphase = asobs_pkg::MP_HI;
				cmd.msel   = asobs_pkg::MS_T_HAT;
				state_next = asobs_pkg::ST_S_FIN;
			end
			asobs_pkg::ST_S_FIN: begin
				cmd.mphase = asobs_pkg::MP_FIN;
				cmd.msel   = asobs_pkg::MS_T_HAT;
				state_next = asobs_pkg::ST_I_LO;
			end
			// integral term; angle update rides along
			asobs_pkg::ST_I_LO: begin
				cmd.mphase   = asobs_pkg::MP_LO;
				cmd.msel     = asobs_pkg::MS_KI_ERR;
				cmd.angle_en = 1'b1;
				state_next   = asobs_pkg::ST_I_HI;
			end
			asobs_pkg::ST_I_HI: begin
				cmd.mphase = asobs_pkg::MP_HI;
				cmd.msel   = asobs_pkg::MS_KI_ERR;
				state_next = asobs_pkg::ST_I_FIN;
			end
			asobs_pkg::ST_I_FIN: begin
				cmd.mphase = asobs_pkg::MP_FIN;
				cmd.msel   = asobs_pkg::MS_KI_ERR;
				state_next = asobs_pkg::ST_W_LO;
			end
			// anti-windup term
			asobs_pkg::ST_W_LO: begin
				cmd.mphase = asobs_pkg::MP_LO;
				cmd.msel   = asobs_pkg::MS_KAW_DIFF;
				cmd.keep_i = 1'b1;
				state_next = asobs_pkg::ST_W_HI;
			end
			asobs_pkg::ST_W_HI: begin
				cmd.mphase = asobs_pkg::MP_HI;
				cmd.msel   = asobs_pkg::MS_KAW_DIFF;
				state_next = asobs_pkg::ST_W_FIN;
			end
			asobs_pkg::ST_W_FIN: begin
				cmd.mphase = asobs_pkg::MP_FIN;
				cmd.msel   = asobs_pkg::MS_KAW_DIFF;
				state_next = asobs_pkg::ST_DELTA;
			end
			asobs_pkg::ST_DELTA: begin
				cmd.delta_en = 1'b1;
				state_next   = asobs_pkg::ST_D_LO;
			end
			// integrator increment, period times delta
			asobs_pkg::ST_D_LO: begin
				cmd.mphase = asobs_pkg::MP_LO;
				cmd.msel   = asobs_pkg::MS_T_DELTA;
				state_next = asobs_pkg::ST_D_HI;
			end
			asobs_pkg::ST_D_HI: begin
				cmd.mphase = asobs_pkg::MP_HI;
				cmd.msel   = asobs_pkg::MS_T_DELTA;
				state_next = asobs_pkg::ST_D_FIN;
			end
			asobs_pkg::ST_D_FIN: begin
				cmd.mphase = asobs_pkg::MP_FIN;
				cmd.msel   = asobs_pkg::MS_T_DELTA;
				state_next = asobs_pkg::ST_INTEG;
			end
			asobs_pkg::ST_INTEG: begin
				cmd.integ_en = 1'b1;
				state_next   = asobs_pkg::ST_OUT;
			end
			// wait for a free output register
			asobs_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next   = asobs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = asobs_pkg::ST_IDLE;
			end
		endcase
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// multiply phases run strictly lo, hi, fin
	a_hi_after_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mphase == asobs_pkg::MP_HI) |-> ($past(cmd.mphase) == asobs_pkg::MP_LO))
		else $error("multiply hi phase without lo phase");

	a_fin_after_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mphase == asobs_pkg::MP_FIN) |-> ($past(cmd.mphase) == asobs_pkg::MP_HI))
		else $error("multiply fin phase without hi phase");

	a_load_presents: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (out_valid_q && (state_q == asobs_pkg::ST_IDLE)))
		else $error("result load did not present a word");

endmodule

/* rtl/asobs_dp.sv */
// ----------------------------------------------------------------------------
// asobs_dp: observer datapath
// Configuration registers, observer state, one shared 33x33 signed
// multiplier with floor and saturation, clamp logic and result register.
// ----------------------------------------------------------------------------
module asobs_dp #(
	parameter int ANGLE_BITS = asobs_pkg::ANGLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [asobs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [asobs_pkg::GAIN_W-1:0]          cfg_wdata,
	input  logic [asobs_pkg::ANGLE_IN_W-1:0]      measured_angle,
	input  asobs_pkg::dp_cmd_t                    cmd,
	output logic signed [asobs_pkg::SPEED_W-1:0]  speed_estimate,
	output logic [asobs_pkg::ANGLE_OUT_W-1:0]     angle_estimate,
	output logic                                  speed_clamped
);

	localparam int FRAC_BITS = asobs_pkg::TRACK_W - ANGLE_BITS;
	localparam int ERR_SHL   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int ERR_SHR   = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
	localparam int ERR_W     = 33 + ERR_SHL;
	localparam int STEP_SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int STEP_SHR  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
	localparam logic [asobs_pkg::TRACK_W-1:0] MEAS_MASK =
		asobs_pkg::TRACK_W'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam logic signed [asobs_pkg::FULL_W-1:0] MUL_LIM =
		asobs_pkg::FULL_W'(64'sd1 <<< 61);
	localparam logic signed [63:0] INTEG_MAX = (64'sd1 <<< 47) - 64'sd1;
	localparam logic signed [63:0] INTEG_MIN = -(64'sd1 <<< 47);

	// configuration
	logic [asobs_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [asobs_pkg::GAIN_W-1:0]  integ_gain_q;
	logic [asobs_pkg::GAIN_W-1:0]  windup_gain_q;
	logic [asobs_pkg::GAIN_W-1:0]  sample_period_q;
	logic [asobs_pkg::LIMIT_W-1:0] speed_limit_q;

	// observer state
	logic signed [asobs_pkg::INTEG_W-1:0] integ_q;
	logic [asobs_pkg::TRACK_W-1:0]        tracked_q;

	// per-sample working registers
	logic signed [ERR_W-1:0]              err_q;
	logic signed [asobs_pkg::UNSAT_W-1:0] unsat_q;
	logic signed [asobs_pkg::HAT_W-1:0]   hat_q;
	logic                                 clamped_q;
	logic signed [asobs_pkg::DIFF_W-1:0]  diff_q;
	logic signed [asobs_pkg::RES_W-1:0]   i_q;
	logic signed [asobs_pkg::RES_W-1:0]   delta_q;
	logic signed [asobs_pkg::RES_W-1:0]   res_q;

	// multiplier
	logic signed [asobs_pkg::PROD_W-1:0]  prod_s1;
	logic [63:0]                          lo_q;

	// result word
	logic signed [asobs_pkg::SPEED_W-1:0] speed_q;
	logic [asobs_pkg::ANGLE_OUT_W-1:0]    angle_q;
	logic                                 flag_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= '0;
			integ_gain_q    <= '0;
			windup_gain_q   <= '0;
			sample_period_q <= asobs_pkg::SAMPLE_PERIOD_RST;
			speed_limit_q   <= '0;
		end else if (cfg_we) begin
			case (asobs_pkg::cfg_idx_t'(cfg_index))
				asobs_pkg::CFG_PROP_GAIN:     prop_gain_q     <= cfg_wdata;
				asobs_pkg::CFG_INTEG_GAIN:    integ_gain_q    <= cfg_wdata;
				asobs_pkg::CFG_WINDUP_GAIN:   windup_gain_q   <= cfg_wdata;
				asobs_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata;
				asobs_pkg::CFG_SPEED_LIMIT:   speed_limit_q   <= cfg_wdata[asobs_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// wrapped angle error in LSB as Q.16; half turn stays positive
	logic [asobs_pkg::TRACK_W-1:0] meas_ext;
	logic [asobs_pkg::TRACK_W-1:0] angle_diff;
	logic signed [32:0]            err_raw;
	logic signed [ERR_W-1:0]       err_wide;
	logic signed [ERR_W-1:0]       err_next;

	assign meas_ext   = ({16'b0, measured_angle} & MEAS_MASK) << FRAC_BITS;
	assign angle_diff = tracked_q - meas_ext;
	assign err_raw    = (angle_diff[31] && (angle_diff[30:0] != '0)) ?
		$signed({1'b1, angle_diff}) : $signed({1'b0, angle_diff});
	assign err_wide   = ERR_W'(err_raw);
	assign err_next   = (ANGLE_BITS >= 16) ? (err_wide <<< ERR_SHL) : (err_wide >>> ERR_SHR);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= err_next;
		end
	end

	// operand select
	logic [asobs_pkg::GAIN_W-1:0]        mul_gain;
	logic signed [asobs_pkg::OPND_W-1:0] mul_opnd;
	logic                                mul_s32;

	always_comb begin
		mul_gain = prop_gain_q;
		mul_opnd = asobs_pkg::OPND_W'(err_q);
		mul_s32  = 1'b0;
		case (cmd.msel)
			asobs_pkg::MS_KP_ERR: begin
				mul_gain = prop_gain_q;
				mul_opnd = asobs_pkg::OPND_W'(err_q);
			end
			asobs_pkg::MS_KI_ERR: begin
				mul_gain = integ_gain_q;
				mul_opnd = asobs_pkg::OPND_W'(err_q);
			end
			asobs_pkg::MS_KAW_DIFF: begin
				mul_gain = windup_gain_q;
				mul_opnd = asobs_pkg::OPND_W'(diff_q);
			end
			asobs_pkg::MS_T_DELTA: begin
				mul_gain = sample_period_q;
				mul_opnd = asobs_pkg::OPND_W'(delta_q);
				mul_s32  = 1'b1;
			end
			asobs_pkg::MS_T_HAT: begin
				mul_gain = sample_period_q;
				mul_opnd = asobs_pkg::OPND_W'(hat_q);
				mul_s32  = 1'b1;
			end
			default: ;
		endcase
	end

	// shared multiplier: low half of the operand first, then the signed high half
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;

	assign mul_a = $signed({1'b0, mul_gain});
	assign mul_b = (cmd.mphase == asobs_pkg::MP_HI) ?
		$signed({mul_opnd[63], mul_opnd[63:32]}) : $signed({1'b0, mul_opnd[31:0]});

	always_ff @(posedge clk) begin
		if (cmd.mphase == asobs_pkg::MP_LO || cmd.mphase == asobs_pkg::MP_HI) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (cmd.mphase == asobs_pkg::MP_HI) begin
			lo_q <= prod_s1[63:0];
		end
	end

	// recombine, floor shift, saturate to +-2^61
	logic signed [asobs_pkg::FULL_W-1:0] mul_full;
	logic signed [asobs_pkg::FULL_W-1:0] mul_shr;
	logic signed [asobs_pkg::FULL_W-1:0] mul_sat;

	assign mul_full = (asobs_pkg::FULL_W'(prod_s1) <<< 32) + $signed({34'b0, lo_q});
	assign mul_shr  = mul_s32 ? (mul_full >>> 32) : (mul_full >>> 16);

	always_comb begin
		mul_sat = mul_shr;
		if (mul_shr > MUL_LIM) begin
			mul_sat = MUL_LIM;
		end else if (mul_shr < -MUL_LIM) begin
			mul_sat = -MUL_LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mphase == asobs_pkg::MP_FIN) begin
			res_q <= asobs_pkg::RES_W'(mul_sat);
		end
	end

	// unclamped speed and clamp
	logic signed [asobs_pkg::UNSAT_W-1:0] unsat_next;
	logic signed [asobs_pkg::HAT_W-1:0]   lim;
	logic signed [asobs_pkg::UNSAT_W-1:0] lim_wide;

	assign unsat_next = asobs_pkg::UNSAT_W'($signed(res_q[asobs_pkg::UNSAT_W-2:0]))
		+ asobs_pkg::UNSAT_W'(integ_q);
	assign lim        = $signed({1'b0, speed_limit_q, 16'b0});
	assign lim_wide   = asobs_pkg::UNSAT_W'(lim);

	always_ff @(posedge clk) begin
		if (cmd.hat_en) begin
			unsat_q <= unsat_next;
			if (unsat_next > lim_wide) begin
				hat_q     <= lim;
				clamped_q <= 1'b1;
			end else if (unsat_next < -lim_wide) begin
				hat_q     <= -lim;
				clamped_q <= 1'b1;
			end else begin
				hat_q     <= asobs_pkg::HAT_W'(unsat_next);
				clamped_q <= 1'b0;
			end
		end
		if (cmd.diff_en) begin
			diff_q <= asobs_pkg::DIFF_W'(hat_q) - asobs_pkg::DIFF_W'(unsat_q);
		end
		if (cmd.keep_i) begin
			i_q <= res_q;
		end
		if (cmd.delta_en) begin
			delta_q <= i_q + res_q;
		end
	end

	// integrator and tracked angle
	logic signed [63:0] integ_sum;
	logic signed [63:0] step_wide;
	logic signed [63:0] step_sh;

	assign integ_sum = 64'(integ_q) + 64'(res_q);
	assign step_wide = 64'(res_q);
	assign step_sh   = (FRAC_BITS >= 16) ? (step_wide <<< STEP_SHL) : (step_wide >>> STEP_SHR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			tracked_q <= '0;
		end else begin
			if (cmd.integ_en) begin
				if (integ_sum > INTEG_MAX) begin
					integ_q <= asobs_pkg::INTEG_W'(INTEG_MAX);
				end else if (integ_sum < INTEG_MIN) begin
					integ_q <= asobs_pkg::INTEG_W'(INTEG_MIN);
				end else begin
					integ_q <= asobs_pkg::INTEG_W'(integ_sum);
				end
			end
			if (cmd.angle_en) begin
				tracked_q <= tracked_q - step_sh[asobs_pkg::TRACK_W-1:0];
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			speed_q <= hat_q[asobs_pkg::HAT_W-1:16];
			angle_q <= asobs_pkg::ANGLE_OUT_W'(tracked_q >> FRAC_BITS);
			flag_q  <= clamped_q;
		end
	end

	assign speed_estimate = speed_q;
	assign angle_estimate = angle_q;
	assign speed_clamped  = flag_q;

	// clamped speed stays inside the limit
	a_hat_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hat_en |=> ((hat_q <= lim) && (hat_q >= -lim)))
		else $error("clamped speed outside limit");

	// flag set exactly when the clamp changed the speed
	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hat_en |=> (clamped_q == (asobs_pkg::UNSAT_W'(hat_q) != unsat_q)))
		else $error("clamp flag disagrees with clamp");

endmodule
